[src/btft_pkg.sv]
package btft_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

    localparam int LIMIT_W = 7;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int TAG_W   = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

endpackage

[src/btft_in_if.sv]
interface btft_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] msg_nr;

    modport source (output valid, output operation, output msg_nr, input ready);
    modport sink (input valid, input operation, input msg_nr, output ready);
endinterface

[src/btft_out_if.sv]
interface btft_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [5:0]  position;
    logic        evicted;
    logic [31:0] evicted_msg_nr;
    logic [6:0]  count;

    modport source (
        output valid, output found, output position, output evicted,
        output evicted_msg_nr, output count, input ready
    );
    modport sink (
        input valid, input found, input position, input evicted,
        input evicted_msg_nr, input count, output ready
    );
endinterface

[src/btft_ctrl.sv]
module btft_ctrl
    import btft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        out_free   = !out_valid_reg || out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the beat until the result register is free
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("load not followed by exec state");

    a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("result not presented after exec");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and exec in the same cycle");

endmodule

[src/btft_dp.sv]
module btft_dp
    import btft_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    input  logic [1:0]          in_operation,
    input  logic [TAG_W-1:0]    in_msg_nr,
    output logic                found,
    output logic [POS_W-1:0]    position,
    output logic                evicted,
    output logic [TAG_W-1:0]    evicted_msg_nr,
    output logic [COUNT_W-1:0]  count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [TAG_W-1:0]   tags_reg [CAPACITY];
    logic [TAG_W-1:0]   tags_next [CAPACITY];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [LIMIT_W-1:0] max_entries_reg;
    op_t                op_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;

    logic               found_reg;
    logic [POS_W-1:0]   position_reg;
    logic               evicted_reg;
    logic [TAG_W-1:0]   ev_tag_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic [LW-1:0]      limit_raw;
    logic [LW-1:0]      limit_eff;
    logic               evict;
    logic               hit;
    logic [IW-1:0]      hit_pos;
    logic               res_found;
    logic               res_evicted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            max_entries_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cmd.exec)
                count_reg <= count_next;
            if (cfg_we)
                max_entries_reg <= cfg_wdata;
        end
    end

    // every cell compares against the incoming tag as the beat is taken
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            match_next[i] = (tags_reg[i] == in_msg_nr) && (CW'(i) < count_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(in_operation);
            tag_reg   <= in_msg_nr;
            match_reg <= match_next;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
                tags_reg[i] <= tags_next[i];
            found_reg     <= res_found;
            position_reg  <= res_found ? POS_W'(hit_pos) : '0;
            evicted_reg   <= res_evicted;
            ev_tag_reg    <= res_evicted ? tags_reg[0] : '0;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    // effective limit clamped to 1..CAPACITY
    always_comb
    begin
        limit_raw = LW'(max_entries_reg);
        if (limit_raw == '0)
            limit_eff = LW'(1);
        else if (limit_raw > LW'(CAPACITY))
            limit_eff = LW'(CAPACITY);
        else
            limit_eff = limit_raw;
        evict = LW'(count_reg) >= limit_eff;
    end

    // newest match wins: highest set index
    always_comb
    begin
        hit     = |match_reg;
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (match_reg[i])
                hit_pos = IW'(i);
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            tags_next[i] = tags_reg[i];
        count_next  = count_reg;
        res_found   = 1'b0;
        res_evicted = 1'b0;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (evict)
                begin
                    // drop the oldest, shift down, new tag lands on top
                    res_evicted = 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++)
                        tags_next[i] = tags_reg[i + 1];
                    for (int i = 0; i < CAPACITY; i++)
                        if (CW'(i) == count_reg - CW'(1))
                            tags_next[i] = tag_reg;
                end
                else if (count_reg < CW'(CAPACITY))
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (CW'(i) == count_reg)
                            tags_next[i] = tag_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                res_found = hit;
                if (hit)
                begin
                    for (int i = 0; i < CAPACITY - 1; i++)
                        if (IW'(i) >= hit_pos)
                            tags_next[i] = tags_reg[i + 1];
                    count_next = count_reg - CW'(1);
                end
            end
            OP_FIND:
            begin
                res_found = hit;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign found          = found_reg;
    assign position       = position_reg;
    assign evicted        = evicted_reg;
    assign evicted_msg_nr = ev_tag_reg;
    assign count          = count_out_reg;

endmodule

[src/bounded_tagged_fifo_table.sv]
// Age-ordered table of 32-bit message numbers held in a row of register
// cells, oldest at position 0. Each operation has a load step, then an
// execute step: in the cycle the beat is accepted every cell compares its
// tag with the incoming one and the match vector is registered; in the
// execute step the newest match is selected, the cells shift or compact in
// one step, and the result lands in the output register. A new beat is
// accepted while the previous result waits, but not before the previous one
// has executed; the execute step stalls only while an untaken result still
// sits in the output register. Reset needs no clearing pass; only the count
// is cleared. max_entries may be written whenever no operation is in flight.
module bounded_tagged_fifo_table
    import btft_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    btft_in_if.sink            cmd,
    btft_out_if.source         rsp
);

    ctrl_cmd_t ctrl_cmd;

    btft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctrl_cmd)
    );

    btft_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctrl_cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_operation   (cmd.operation),
        .in_msg_nr      (cmd.msg_nr),
        .found          (rsp.found),
        .position       (rsp.position),
        .evicted        (rsp.evicted),
        .evicted_msg_nr (rsp.evicted_msg_nr),
        .count          (rsp.count)
    );

endmodule
